// ===== rtl/cpag_pkg.sv =====
// Package for the chess piece attack generator: piece codes, ray direction tables
// and constant pattern functions for the attack logic, the top level and the checker.
// Depends on nothing.
package cpag_pkg;

    localparam int SQ_W    = 6;
    localparam int BOARD_W = 64;
    localparam int OP_W    = 3;
    localparam int NUM_DIR = 8;

    typedef logic [BOARD_W-1:0] board_t;
    typedef logic [SQ_W-1:0]    square_t;
    typedef logic [OP_W-1:0]    op_t;

    // Piece kinds. Codes six and seven are unused and attack nothing.
    localparam op_t OP_KNIGHT     = 3'd0;
    localparam op_t OP_KING       = 3'd1;
    localparam op_t OP_WHITE_PAWN = 3'd2;
    localparam op_t OP_BLACK_PAWN = 3'd3;
    localparam op_t OP_BISHOP     = 3'd4;
    localparam op_t OP_ROOK       = 3'd5;
    localparam op_t OP_UNUSED_LO  = 3'd6;
    localparam op_t OP_UNUSED_HI  = 3'd7;

    // Knight leaps.
    localparam int LEAP_FILE [8] = '{1, 2, 2, -1 + 2, -1, -2, -2, -1};
    localparam int LEAP_RANK [8] = '{2, 1, -1, -2, -2, -1, 1, 2};

    // Ray directions: N, S, E, W, NE, NW, SE, SW.
    localparam int RAY_FILE [8] = '{0, 0, 1, -1, 1, -1, 1, -1};
    localparam int RAY_RANK [8] = '{1, -1, 0, 0, 1, 1, -1, -1};

    // Set where the ray runs toward higher square numbers (N, E, NE, NW).
    localparam logic [NUM_DIR-1:0] RAY_UP = 8'b0011_0101;

    function automatic board_t sq_bit(input int f, input int r);
        board_t b;
        b = '0;
        if (f >= 0 && f <= 7 && r >= 0 && r <= 7)
        begin
            b[r*8 + f] = 1'b1;
        end
        return b;
    endfunction

    // Every square on one ray from the origin, stopping at the board edge.
    function automatic board_t ray_mask(input square_t sq, input int dir);
        int     f;
        int     r;
        board_t m;
        f = int'(sq[2:0]);
        r = int'(sq[5:3]);
        m = '0;
        for (int k = 1; k < 8; k++)
        begin
            m |= sq_bit(f + k * RAY_FILE[dir], r + k * RAY_RANK[dir]);
        end
        return m;
    endfunction

    function automatic board_t knight_mask(input square_t sq);
        int     f;
        int     r;
        board_t m;
        f = int'(sq[2:0]);
        r = int'(sq[5:3]);
        m = '0;
        for (int i = 0; i < 8; i++)
        begin
            m |= sq_bit(f + LEAP_FILE[i], r + LEAP_RANK[i]);
        end
        return m;
    endfunction

    function automatic board_t king_mask(input square_t sq);
        int     f;
        int     r;
        board_t m;
        f = int'(sq[2:0]);
        r = int'(sq[5:3]);
        m = '0;
        for (int df = -1; df <= 1; df++)
        begin
            for (int dr = -1; dr <= 1; dr++)
            begin
                if (df != 0 || dr != 0)
                begin
                    m |= sq_bit(f + df, r + dr);
                end
            end
        end
        return m;
    endfunction

    // A pawn attacks the two diagonal squares one rank ahead; dr is +1 or -1.
    function automatic board_t pawn_mask(input square_t sq, input int dr);
        int f;
        int r;
        f = int'(sq[2:0]);
        r = int'(sq[5:3]);
        return sq_bit(f - 1, r + dr) | sq_bit(f + 1, r + dr);
    endfunction

    function automatic board_t reverse_board(input board_t b);
        board_t v;
        for (int i = 0; i < BOARD_W; i++)
        begin
            v[i] = b[BOARD_W-1-i];
        end
        return v;
    endfunction

endpackage

// ===== rtl/cpag_attack_logic.sv =====
// Combinational attack board for one query: leaper patterns and blocked sliding rays.
// Depends on cpag_pkg.
module cpag_attack_logic
    import cpag_pkg::*;
(
    input  op_t     op,
    input  square_t square,
    input  board_t  occupancy,
    output board_t  attacks
);

    board_t ray_att [NUM_DIR];

    // Each ray keeps its squares up to and including the nearest blocker. For rays
    // running toward lower squares the board is mirrored so that the nearest
    // blocker is always the lowest set bit.
    for (genvar d = 0; d < NUM_DIR; d++)
    begin : g_ray
        board_t ray;
        board_t blk;
        board_t lsb;
        assign ray = RAY_UP[d] ? ray_mask(square, d) : reverse_board(ray_mask(square, d));
        assign blk = ray & (RAY_UP[d] ? occupancy : reverse_board(occupancy));
        assign lsb = blk & (~blk + board_t'(1));
        // With no blocker lsb is zero and lsb - 1 is all ones, keeping the whole ray.
        assign ray_att[d] = RAY_UP[d] ? (ray & (lsb | (lsb - board_t'(1))))
                                      : reverse_board(ray & (lsb | (lsb - board_t'(1))));
    end

    always_comb
    begin
        unique case (op)
            OP_KNIGHT:     attacks = knight_mask(square);
            OP_KING:       attacks = king_mask(square);
            OP_WHITE_PAWN: attacks = pawn_mask(square, 1);
            OP_BLACK_PAWN: attacks = pawn_mask(square, -1);
            OP_BISHOP:     attacks = ray_att[4] | ray_att[5] | ray_att[6] | ray_att[7];
            OP_ROOK:       attacks = ray_att[0] | ray_att[1] | ray_att[2] | ray_att[3];
            default:       attacks = '0;
        endcase
    end

endmodule

// ===== rtl/chess_piece_attack_generator.sv =====
// An accepted transaction passes the input register, then the result register, before its
// result is valid. Throughput: one transaction per cycle unless the output side stalls, set
// by the single pass of attack logic between the input register and the result register.
// Reset (rst_n, asynchronous, active low) empties both stages; the payload is not reset.
// Depends on cpag_pkg and cpag_attack_logic.
module chess_piece_attack_generator
    import cpag_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  op_t     op,
    input  square_t square,
    input  board_t  occupancy,
    output logic    out_valid,
    input  logic    out_stall,
    output board_t  attacks
);

    // Stage one holds the query as accepted; stage two holds the finished board.
    logic    s1_valid_reg;
    logic    s1_valid_next;
    op_t     op_reg;
    square_t square_reg;
    board_t  occ_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    board_t  attacks_reg;
    board_t  attacks_next;

    logic    s2_advance;
    logic    s1_advance;

    // The result stage moves when it is empty or its transaction is being taken.
    // The input stage moves when it is empty or when it can hand off to the result
    // stage, so a new transaction is taken even while a finished result waits,
    // as long as stage one is free.
    assign s2_advance = !out_valid_reg || !out_stall;
    assign s1_advance = !s1_valid_reg || s2_advance;
    assign in_stall   = !s1_advance;

    assign s1_valid_next  = s1_advance ? in_valid : s1_valid_reg;
    assign out_valid_next = s2_advance ? s1_valid_reg : out_valid_reg;

    // All per-query work sits between the two registers.
    cpag_attack_logic u_attack_logic
    (
        .op        (op_reg),
        .square    (square_reg),
        .occupancy (occ_reg),
        .attacks   (attacks_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers load only when their stage moves, so a stalled result holds.
    always_ff @(posedge clk)
    begin
        if (s1_advance && in_valid)
        begin
            op_reg     <= op;
            square_reg <= square;
            occ_reg    <= occupancy;
        end
        if (s2_advance && s1_valid_reg)
        begin
            attacks_reg <= attacks_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign attacks   = attacks_reg;

endmodule

// ===== rtl/cpag_checker.sv =====
// Port-level checker for the chess piece attack generator, attached by bind.
// Depends on cpag_pkg and chess_piece_attack_generator.
module cpag_checker
    import cpag_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_stall,
    input op_t     op,
    input logic    out_valid,
    input logic    out_stall,
    input board_t  attacks
);

    // A held result stays valid and unchanged until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(attacks))
        else $error("stalled result transaction changed or vanished");

    // The input side stalls only when a result is waiting behind a stalled output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    // An accepted unused piece code yields an empty board once it has passed both stages with the path free.
    a_unused_op: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (op == OP_UNUSED_LO || op == OP_UNUSED_HI)
        ##1 (!out_valid || !out_stall)
        |=> out_valid && attacks == '0)
        else $error("unused piece code gave a nonempty board");

    // A knight always attacks between two and eight squares.
    a_knight_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op == OP_KNIGHT ##1 (!out_valid || !out_stall)
        |=> out_valid && $countones(attacks) >= 2 && $countones(attacks) <= 8)
        else $error("knight attack count out of range");

endmodule

bind chess_piece_attack_generator cpag_checker u_cpag_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .attacks   (attacks)
);
